>>> design/qalu_pkg.sv
`timescale 1ns / 1ps

package qalu_pkg;

   localparam int FRAC_BITS = 16;

   localparam int WORD_W     = 32;
   localparam int DIFF_W     = WORD_W + 1;
   localparam int PROD_W     = WORD_W + DIFF_W;
   localparam int HAM_W      = PROD_W + 1;
   localparam int SQP_W      = 2 * DIFF_W;
   localparam int SQ_W       = SQP_W + 2;
   localparam int ROOT_W     = SQ_W / 2;
   localparam int REM_W      = ROOT_W + 1;
   localparam int SCALAR_W   = WORD_W - 1;
   localparam int BASE_W     = HAM_W - 1;
   localparam int DEN_W      = SQP_W + 1;
   localparam int D2_W       = DEN_W + 1;
   localparam int MAG_W      = (FRAC_BITS + BASE_W > 3 * FRAC_BITS + WORD_W) ?
                               FRAC_BITS + BASE_W : 3 * FRAC_BITS + WORD_W;
   localparam int NUM_W      = MAG_W + 2;
   localparam int QUO_W      = WORD_W;
   localparam int HI_W       = NUM_W - QUO_W;
   localparam int CMP_W      = (HI_W > D2_W) ? HI_W : D2_W;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int DIV_STEPS  = QUO_W;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_MUL    = 4'd2,
      OP_DIV    = 4'd3,
      OP_SCALE  = 4'd4,
      OP_CONJ   = 4'd5,
      OP_NORM   = 4'd6,
      OP_NORMZ  = 4'd7,
      OP_INV    = 4'd8,
      OP_EUCLID = 4'd9,
      OP_CHEB   = 4'd10
   } op_type;

   // products summed, squares summed
   typedef struct packed {
      logic                         valid;
      op_type                       op;
      logic                         err;
      logic [3:0][WORD_W-1:0]       early_res;
      logic [SCALAR_W-1:0]          early_scalar;
      logic [3:0][HAM_W-1:0]        ham;
      logic [SQ_W-1:0]              nsq;
      logic [3:0][WORD_W-1:0]       p;
   } fr_type;

   typedef struct packed {
      fr_type                       pay;
      logic [SQ_W-1:0]              rad;
      logic [ROOT_W-1:0]            root;
      logic [REM_W-1:0]             rem;
   } sq_type;

   typedef struct packed {
      logic                         valid;
      op_type                       op;
      logic                         err;
      logic [3:0][WORD_W-1:0]       early_res;
      logic [SCALAR_W-1:0]          early_scalar;
      logic [ROOT_W-1:0]            root_r;
      logic [3:0]                   neg;
      logic [3:0]                   ovf;
      logic [3:0][D2_W-1:0]         rem;
      logic [3:0][QUO_W-1:0]        nq;
      logic [D2_W-1:0]              d2;
   } dv_type;

endpackage

>>> design/quaternion_alu_core.sv
`timescale 1ns / 1ps
// a request passes through 73 register stages (3 multiply/sum stages, 34 square-root
// stages, 3 divider setup stages, 32 divider stages, 1 output register); every opcode
// takes the same path
// throughput: one request per cycle; a stalled output parks one result in the skid
// register, then req_stall freezes the whole pipe until the skid drains
// reset clears all valid bits; data registers are not reset
module quaternion_alu_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [3:0]         req_opcode,
   input  logic signed [31:0] req_first_w,
   input  logic signed [31:0] req_first_x,
   input  logic signed [31:0] req_first_y,
   input  logic signed [31:0] req_first_z,
   input  logic signed [31:0] req_second_w,
   input  logic signed [31:0] req_second_x,
   input  logic signed [31:0] req_second_y,
   input  logic signed [31:0] req_second_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_res_w,
   output logic signed [31:0] rsp_res_x,
   output logic signed [31:0] rsp_res_y,
   output logic signed [31:0] rsp_res_z,
   output logic [30:0]        rsp_res_scalar,
   output logic               rsp_div_error
);

   localparam int WW = qalu_pkg::WORD_W;
   localparam int CW = qalu_pkg::SCALAR_W;
   localparam int RW = qalu_pkg::ROOT_W;
   localparam int QW = qalu_pkg::QUO_W;

   typedef struct packed {
      logic [3:0][WW-1:0] res;
      logic [CW-1:0]      scalar;
      logic               err;
   } out_type;

   logic [3:0][31:0] first_q;
   logic [3:0][31:0] second_q;
   logic             advance;

   qalu_pkg::fr_type front_q;
   qalu_pkg::sq_type sq_pipe [0:qalu_pkg::SQRT_STEPS];
   qalu_pkg::dv_type dv_pipe [0:qalu_pkg::DIV_STEPS];
   qalu_pkg::dv_type last_q;

   out_type fmt;
   out_type out_ff, out_in;
   out_type skid_ff, skid_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    skid_valid_ff, skid_valid_in;

   assign first_q  = {req_first_z, req_first_y, req_first_x, req_first_w};
   assign second_q = {req_second_z, req_second_y, req_second_x, req_second_w};

   // whole pipeline moves unless the skid register is holding a result
   assign advance   = !skid_valid_ff;
   assign req_stall = skid_valid_ff;

   qalu_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (advance),
      .in_valid  (req_valid),
      .in_opcode (req_opcode),
      .in_first  (first_q),
      .in_second (second_q),
      .front_out (front_q)
   );

   assign sq_pipe[0] = '{pay: front_q, rad: front_q.nsq, root: '0, rem: '0};

   for (genvar g = 0; g < qalu_pkg::SQRT_STEPS; g++) begin : g_sqrt
      qalu_sqrt_step u_step (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .step_in  (sq_pipe[g]),
         .step_out (sq_pipe[g+1])
      );
   end

   qalu_prep u_prep (
      .clock    (clock),
      .reset    (reset),
      .enable   (advance),
      .prep_in  (sq_pipe[qalu_pkg::SQRT_STEPS]),
      .prep_out (dv_pipe[0])
   );

   for (genvar g = 0; g < qalu_pkg::DIV_STEPS; g++) begin : g_div
      qalu_div_step u_step (
         .clock    (clock),
         .reset    (reset),
         .enable   (advance),
         .step_in  (dv_pipe[g]),
         .step_out (dv_pipe[g+1])
      );
   end

   assign last_q = dv_pipe[qalu_pkg::DIV_STEPS];

   // sign, saturation and opcode select of the finished request
   always_comb begin
      logic [3:0][WW-1:0] rnd;
      logic [QW-1:0]      q;
      logic               sat;
      for (int i = 0; i < 4; i++) begin
         q = last_q.nq[i];
         if (last_q.neg[i]) begin
            sat = last_q.ovf[i] | (q[QW-1] & (q[QW-2:0] != '0));
            rnd[i] = sat ? {1'b1, {(WW-1){1'b0}}} : WW'(-q);
         end else begin
            sat = last_q.ovf[i] | q[QW-1];
            rnd[i] = sat ? {1'b0, {(WW-1){1'b1}}} : WW'(q);
         end
      end
      fmt = '0;
      fmt.err = last_q.err;
      case (last_q.op)
         qalu_pkg::OP_ADD, qalu_pkg::OP_SUB, qalu_pkg::OP_CONJ: fmt.res = last_q.early_res;
         qalu_pkg::OP_MUL, qalu_pkg::OP_SCALE:                  fmt.res = rnd;
         qalu_pkg::OP_DIV, qalu_pkg::OP_NORMZ, qalu_pkg::OP_INV:
            fmt.res = last_q.err ? '0 : rnd;
         qalu_pkg::OP_NORM, qalu_pkg::OP_EUCLID:
            fmt.scalar = (last_q.root_r[RW-1:CW] != '0) ? {CW{1'b1}} : last_q.root_r[CW-1:0];
         qalu_pkg::OP_CHEB:                                     fmt.scalar = last_q.early_scalar;
         default:                                               fmt = '0;
      endcase
   end

   always_comb begin
      out_in = out_ff;
      skid_in = skid_ff;
      rsp_valid_in = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!skid_valid_ff) begin
         if (rsp_valid_ff && rsp_stall) begin
            // output held: park the next finished request
            skid_in = fmt;
            skid_valid_in = last_q.valid;
         end else begin
            out_in = fmt;
            rsp_valid_in = last_q.valid;
         end
      end else if (!rsp_stall) begin
         out_in = skid_ff;
         skid_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
         out_ff <= out_in;
         skid_ff <= skid_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_res_w      = $signed(out_ff.res[0]);
   assign rsp_res_x      = $signed(out_ff.res[1]);
   assign rsp_res_y      = $signed(out_ff.res[2]);
   assign rsp_res_z      = $signed(out_ff.res[3]);
   assign rsp_res_scalar = out_ff.scalar;
   assign rsp_div_error  = out_ff.err;

   a_skid_fill: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled while output was free");

   a_skid_order: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a result ahead of an empty output");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && out_ff.err) |-> (out_ff.res == '0 && out_ff.scalar == '0))
      else $error("zero norm request returned nonzero result");

endmodule

>>> design/qalu_front.sv
`timescale 1ns / 1ps

module qalu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [3:0]            in_opcode,
   input  logic [3:0][31:0]      in_first,
   input  logic [3:0][31:0]      in_second,
   output qalu_pkg::fr_type      front_out
);

   localparam int WW = qalu_pkg::WORD_W;
   localparam int DW = qalu_pkg::DIFF_W;
   localparam int PW = qalu_pkg::PROD_W;
   localparam int HW = qalu_pkg::HAM_W;
   localparam int QW = qalu_pkg::SQP_W;
   localparam int SW = qalu_pkg::SQ_W;
   localparam int CW = qalu_pkg::SCALAR_W;

   typedef struct packed {
      logic                     valid;
      qalu_pkg::op_type         op;
      logic                     err;
      logic [3:0][WW-1:0]       early_res;
      logic [3:0][DW-1:0]       vmag;
      logic [3:0][WW-1:0]       ham_a;
      logic [3:0][DW-1:0]       ham_b;
      logic [3:0][WW-1:0]       p;
   } a_type;

   typedef struct packed {
      logic                     valid;
      qalu_pkg::op_type         op;
      logic                     err;
      logic [3:0][WW-1:0]       early_res;
      logic [CW-1:0]            early_scalar;
      logic [3:0][3:0][PW-1:0]  prod;
      logic [3:0][QW-1:0]       sq;
      logic [3:0][WW-1:0]       p;
   } b_type;

   a_type            a_in, a_ff;
   b_type            b_in, b_ff;
   qalu_pkg::fr_type fr_in, fr_ff;
   qalu_pkg::op_type op;

   function automatic logic [WW-1:0] sat_word(input logic signed [DW-1:0] v);
      logic [WW-1:0] r;
      if (v[DW-1] != v[DW-2]) begin
         r = v[DW-1] ? {1'b1, {(WW-1){1'b0}}} : {1'b0, {(WW-1){1'b1}}};
      end else begin
         r = v[WW-1:0];
      end
      return r;
   endfunction

   function automatic logic [HW-1:0] sx(input logic [PW-1:0] v);
      return HW'($signed(v));
   endfunction

   // stage a: operand select, simple results
   always_comb begin
      logic signed [DW-1:0] pv;
      logic signed [DW-1:0] qv;
      logic signed [DW-1:0] sum;
      logic signed [DW-1:0] dif;
      logic signed [DW-1:0] neg;
      logic signed [DW-1:0] v;
      op = qalu_pkg::op_type'(in_opcode);
      a_in = '0;
      a_in.valid = in_valid;
      a_in.op = op;
      a_in.p = in_first;
      a_in.err = ((op == qalu_pkg::OP_DIV) && (in_second == '0)) ||
                 ((op inside {qalu_pkg::OP_NORMZ, qalu_pkg::OP_INV}) && (in_first == '0));
      for (int i = 0; i < 4; i++) begin
         pv = DW'($signed(in_first[i]));
         qv = DW'($signed(in_second[i]));
         sum = pv + qv;
         dif = pv - qv;
         neg = -pv;
         case (op)
            qalu_pkg::OP_ADD:  a_in.early_res[i] = sat_word(sum);
            qalu_pkg::OP_SUB:  a_in.early_res[i] = sat_word(dif);
            qalu_pkg::OP_CONJ: a_in.early_res[i] = (i == 0) ? in_first[i] : sat_word(neg);
            default:           a_in.early_res[i] = '0;
         endcase
         case (op)
            qalu_pkg::OP_DIV:                     v = qv;
            qalu_pkg::OP_EUCLID, qalu_pkg::OP_CHEB: v = dif;
            default:                              v = pv;
         endcase
         a_in.vmag[i] = v[DW-1] ? DW'(-v) : DW'(v);
         a_in.ham_a[i] = ((op == qalu_pkg::OP_SCALE) && (i != 0)) ? '0 : in_first[i];
         a_in.ham_b[i] = ((op == qalu_pkg::OP_DIV) && (i != 0)) ? DW'(-qv) : DW'(qv);
      end
   end

   // stage b: sixteen products, four squares, largest lane magnitude
   always_comb begin
      logic [DW-1:0] m01;
      logic [DW-1:0] m23;
      logic [DW-1:0] mx;
      b_in.valid = a_ff.valid;
      b_in.op = a_ff.op;
      b_in.err = a_ff.err;
      b_in.early_res = a_ff.early_res;
      b_in.p = a_ff.p;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            b_in.prod[i][j] = PW'($signed(a_ff.ham_a[i])) * PW'($signed(a_ff.ham_b[j]));
         end
         b_in.sq[i] = QW'(a_ff.vmag[i]) * QW'(a_ff.vmag[i]);
      end
      m01 = (a_ff.vmag[0] > a_ff.vmag[1]) ? a_ff.vmag[0] : a_ff.vmag[1];
      m23 = (a_ff.vmag[2] > a_ff.vmag[3]) ? a_ff.vmag[2] : a_ff.vmag[3];
      mx = (m01 > m23) ? m01 : m23;
      b_in.early_scalar = (mx[DW-1:CW] != '0) ? {CW{1'b1}} : mx[CW-1:0];
   end

   // stage c: hamilton sums and sum of squares
   always_comb begin
      fr_in.valid = b_ff.valid;
      fr_in.op = b_ff.op;
      fr_in.err = b_ff.err;
      fr_in.early_res = b_ff.early_res;
      fr_in.early_scalar = b_ff.early_scalar;
      fr_in.p = b_ff.p;
      fr_in.ham[0] = sx(b_ff.prod[0][0]) - sx(b_ff.prod[1][1])
                   - sx(b_ff.prod[2][2]) - sx(b_ff.prod[3][3]);
      fr_in.ham[1] = sx(b_ff.prod[0][1]) + sx(b_ff.prod[1][0])
                   + sx(b_ff.prod[2][3]) - sx(b_ff.prod[3][2]);
      fr_in.ham[2] = sx(b_ff.prod[0][2]) + sx(b_ff.prod[2][0])
                   + sx(b_ff.prod[3][1]) - sx(b_ff.prod[1][3]);
      fr_in.ham[3] = sx(b_ff.prod[0][3]) + sx(b_ff.prod[3][0])
                   + sx(b_ff.prod[1][2]) - sx(b_ff.prod[2][1]);
      fr_in.nsq = SW'(b_ff.sq[0]) + SW'(b_ff.sq[1]) + SW'(b_ff.sq[2]) + SW'(b_ff.sq[3]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.valid <= 1'b0;
         b_ff.valid <= 1'b0;
         fr_ff.valid <= 1'b0;
      end else if (enable) begin
         a_ff <= a_in;
         b_ff <= b_in;
         fr_ff <= fr_in;
      end
   end

   assign front_out = fr_ff;

endmodule

>>> design/qalu_sqrt_step.sv
`timescale 1ns / 1ps

module qalu_sqrt_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  qalu_pkg::sq_type step_in,
   output qalu_pkg::sq_type step_out
);

   localparam int SW = qalu_pkg::SQ_W;
   localparam int RW = qalu_pkg::ROOT_W;
   localparam int MW = qalu_pkg::REM_W;
   localparam int CUR_W = MW + 2;

   qalu_pkg::sq_type step_in_c, step_ff;
   logic [CUR_W-1:0] cur;
   logic [CUR_W-1:0] trial;
   logic             ge;

   // one root bit per stage, two radicand bits consumed
   always_comb begin
      cur = {step_in.rem, step_in.rad[SW-1 -: 2]};
      trial = CUR_W'({step_in.root, 2'b01});
      ge = (cur >= trial);
      step_in_c = step_in;
      step_in_c.rad = step_in.rad << 2;
      step_in_c.root = {step_in.root[RW-2:0], ge};
      step_in_c.rem = ge ? MW'(cur - trial) : MW'(cur);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.pay.valid <= 1'b0;
      end else if (enable) begin
         step_ff <= step_in_c;
      end
   end

   assign step_out = step_ff;

endmodule

>>> design/qalu_prep.sv
`timescale 1ns / 1ps

module qalu_prep (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  qalu_pkg::sq_type prep_in,
   output qalu_pkg::dv_type prep_out
);

   localparam int F   = qalu_pkg::FRAC_BITS;
   localparam int WW  = qalu_pkg::WORD_W;
   localparam int HW  = qalu_pkg::HAM_W;
   localparam int BW  = qalu_pkg::BASE_W;
   localparam int RW  = qalu_pkg::ROOT_W;
   localparam int MW  = qalu_pkg::REM_W;
   localparam int CW  = qalu_pkg::SCALAR_W;
   localparam int NW  = qalu_pkg::DEN_W;
   localparam int D2W = qalu_pkg::D2_W;
   localparam int GW  = qalu_pkg::MAG_W;
   localparam int UW  = qalu_pkg::NUM_W;
   localparam int QW  = qalu_pkg::QUO_W;
   localparam int KW  = qalu_pkg::CMP_W;

   typedef struct packed {
      logic                  valid;
      qalu_pkg::op_type      op;
      logic                  err;
      logic [3:0][WW-1:0]    early_res;
      logic [CW-1:0]         early_scalar;
      logic [RW-1:0]         root_r;
      logic [NW-1:0]         nsq;
      logic [3:0]            neg;
      logic [3:0][BW-1:0]    base;
   } p1_type;

   typedef struct packed {
      logic                  valid;
      qalu_pkg::op_type      op;
      logic                  err;
      logic [3:0][WW-1:0]    early_res;
      logic [CW-1:0]         early_scalar;
      logic [RW-1:0]         root_r;
      logic [3:0]            neg;
      logic [3:0][UW-1:0]    num;
      logic [D2W-1:0]        d2;
   } p2_type;

   p1_type           p1_in, p1_ff;
   p2_type           p2_in, p2_ff;
   qalu_pkg::dv_type p3_in, p3_ff;

   // root rounding, sign and magnitude of each numerator
   always_comb begin
      logic signed [HW-1:0] s;
      logic        [HW-1:0] mag;
      p1_in.valid = prep_in.pay.valid;
      p1_in.op = prep_in.pay.op;
      p1_in.err = prep_in.pay.err;
      p1_in.early_res = prep_in.pay.early_res;
      p1_in.early_scalar = prep_in.pay.early_scalar;
      p1_in.nsq = prep_in.pay.nsq[NW-1:0];
      p1_in.root_r = (prep_in.rem > MW'(prep_in.root)) ? prep_in.root + 1'b1 : prep_in.root;
      for (int i = 0; i < 4; i++) begin
         if (prep_in.pay.op inside {qalu_pkg::OP_NORMZ, qalu_pkg::OP_INV}) begin
            s = HW'($signed(prep_in.pay.p[i]));
         end else begin
            s = $signed(prep_in.pay.ham[i]);
         end
         // inverse negates the vector part
         p1_in.neg[i] = s[HW-1] ^ ((prep_in.pay.op == qalu_pkg::OP_INV) && (i != 0));
         mag = s[HW-1] ? HW'(-s) : HW'(s);
         p1_in.base[i] = mag[BW-1:0];
      end
   end

   // scale numerator, pick divisor, form 2*num + den over 2*den
   always_comb begin
      logic [NW-1:0] den;
      logic [GW-1:0] m;
      p2_in.valid = p1_ff.valid;
      p2_in.op = p1_ff.op;
      p2_in.err = p1_ff.err;
      p2_in.early_res = p1_ff.early_res;
      p2_in.early_scalar = p1_ff.early_scalar;
      p2_in.root_r = p1_ff.root_r;
      p2_in.neg = p1_ff.neg;
      case (p1_ff.op)
         qalu_pkg::OP_DIV, qalu_pkg::OP_INV: den = p1_ff.nsq;
         qalu_pkg::OP_NORMZ:                 den = NW'(p1_ff.root_r);
         default:                            den = NW'(1) << F;
      endcase
      p2_in.d2 = {den, 1'b0};
      for (int i = 0; i < 4; i++) begin
         case (p1_ff.op)
            qalu_pkg::OP_DIV, qalu_pkg::OP_NORMZ: m = GW'(p1_ff.base[i]) << F;
            qalu_pkg::OP_INV:                     m = GW'(p1_ff.base[i]) << (3 * F);
            default:                              m = GW'(p1_ff.base[i]);
         endcase
         p2_in.num[i] = UW'({m, 1'b0}) + UW'(den);
      end
   end

   // overflow check and first partial remainder
   always_comb begin
      logic [KW-1:0] hi;
      p3_in.valid = p2_ff.valid;
      p3_in.op = p2_ff.op;
      p3_in.err = p2_ff.err;
      p3_in.early_res = p2_ff.early_res;
      p3_in.early_scalar = p2_ff.early_scalar;
      p3_in.root_r = p2_ff.root_r;
      p3_in.neg = p2_ff.neg;
      p3_in.d2 = p2_ff.d2;
      for (int i = 0; i < 4; i++) begin
         hi = KW'(p2_ff.num[i] >> QW);
         p3_in.ovf[i] = (hi >= KW'(p2_ff.d2));
         p3_in.rem[i] = hi[D2W-1:0];
         p3_in.nq[i] = p2_ff.num[i][QW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_ff.valid <= 1'b0;
         p2_ff.valid <= 1'b0;
         p3_ff.valid <= 1'b0;
      end else if (enable) begin
         p1_ff <= p1_in;
         p2_ff <= p2_in;
         p3_ff <= p3_in;
      end
   end

   assign prep_out = p3_ff;

endmodule

>>> design/qalu_div_step.sv
`timescale 1ns / 1ps

module qalu_div_step (
   input  logic             clock,
   input  logic             reset,
   input  logic             enable,
   input  qalu_pkg::dv_type step_in,
   output qalu_pkg::dv_type step_out
);

   localparam int D2W = qalu_pkg::D2_W;
   localparam int QW  = qalu_pkg::QUO_W;

   qalu_pkg::dv_type step_in_c, step_ff;

   // restoring division, one quotient bit per lane per stage
   always_comb begin
      logic [D2W:0] r2;
      logic         ge;
      step_in_c = step_in;
      for (int i = 0; i < 4; i++) begin
         r2 = {step_in.rem[i], step_in.nq[i][QW-1]};
         ge = (r2 >= {1'b0, step_in.d2});
         step_in_c.rem[i] = ge ? D2W'(r2 - {1'b0, step_in.d2}) : D2W'(r2);
         step_in_c.nq[i] = {step_in.nq[i][QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff.valid <= 1'b0;
      end else if (enable) begin
         step_ff <= step_in_c;
      end
   end

   assign step_out = step_ff;

endmodule
